// ===== design/gjfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gjfs_pkg
// types and constants shared by the first-fit gpu job scheduler
// ----------------------------------------------------------------------------
package gjfs_pkg;

  localparam int unsigned GpusDef      = 8;
  localparam int unsigned WaitDepthDef = 16;
  localparam int unsigned RunDepthDef  = 16;
  localparam int unsigned IdBitsDef    = 16;

  localparam logic [3:0] GpuTotalRst = 4'd8;

  typedef enum logic [1:0] {
    ACT_SUBMIT = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_RETRY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    EV_ACCEPTED  = 3'd0,
    EV_STARTED   = 3'd1,
    EV_STOPPED   = 3'd2,
    EV_CANCELLED = 3'd3,
    EV_FULL      = 3'd4,
    EV_UNKNOWN   = 3'd5
  } event_e;

  typedef enum logic {
    CFG_GPU_TOTAL = 1'b0,
    CFG_MACHINE_RUNNING = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUBMIT,
    ST_CANCEL,
    ST_START
  } state_e;

  typedef struct packed {
    logic [1:0]           action;
    logic [IdBitsDef-1:0] task_id;
    logic [3:0]           req_count;
    logic [GpusDef-1:0]   req_mask;
  } in_word_t;

  typedef struct packed {
    logic [2:0]           event_res;
    logic [IdBitsDef-1:0] job_id;
    logic [GpusDef-1:0]   gpu_mask;
    logic                 last;
  } out_word_t;

  // control from the sequencer to the wait cells
  typedef struct packed {
    logic shift;   // every cell at or above the cut takes its upper neighbor
    logic load;    // the first empty cell takes the new job
  } wait_ctl_t;

endpackage

// ===== design/gjfs_wait_cell.sv =====
// ----------------------------------------------------------------------------
// gjfs_wait_cell
// one entry of the compacted wait queue; shifts down from its upper neighbor
// ----------------------------------------------------------------------------
module gjfs_wait_cell #(
  parameter int unsigned IdBits = gjfs_pkg::IdBitsDef,
  parameter int unsigned Gpus   = gjfs_pkg::GpusDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gjfs_pkg::wait_ctl_t ctl_i,
  input  logic              cut_i,      // this cell is at or above the removed one
  input  logic              first_free_i,
  input  logic              up_valid_i,
  input  logic [IdBits-1:0] up_id_i,
  input  logic [3:0]        up_count_i,
  input  logic [Gpus-1:0]   up_mask_i,
  input  logic [IdBits-1:0] new_id_i,
  input  logic [3:0]        new_count_i,
  input  logic [Gpus-1:0]   new_mask_i,
  output logic              valid_o,
  output logic [IdBits-1:0] id_o,
  output logic [3:0]        count_o,
  output logic [Gpus-1:0]   mask_o
);

  logic valid_q;
  logic [IdBits-1:0] id_q;
  logic [3:0] count_q;
  logic [Gpus-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift && cut_i) begin
      valid_q <= up_valid_i;
    end else if (ctl_i.load && first_free_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift && cut_i) begin
      id_q    <= up_id_i;
      count_q <= up_count_i;
      mask_q  <= up_mask_i;
    end else if (ctl_i.load && first_free_i) begin
      id_q    <= new_id_i;
      count_q <= new_count_i;
      mask_q  <= new_mask_i;
    end
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign count_o = count_q;
  assign mask_o  = mask_q;

endmodule

// ===== design/gpu_job_first_fit_scheduler.sv =====
// ----------------------------------------------------------------------------
// gpu_job_first_fit_scheduler
// first-fit dispatcher of gpu jobs over a compacted wait queue
// ----------------------------------------------------------------------------
// One word is taken at a time. A cancel or a retry is handled in its own state,
// which waits for a free output register, before the next input word can be
// taken; a submit first queues the job and then makes one start try per cycle
// while the output register is free, until a try fails. Each try looks at every
// wait cell and run slot at once. The wait queue is a row of cells that close a
// gap by shifting down one position. A result word is held in an output register
// until taken, and a new word waits while that register is full and not taken.
// The accepted word of a submit waits in a second register until the next start
// try tells whether it is the last.
module gpu_job_first_fit_scheduler #(
  parameter int unsigned WAIT_DEPTH = gjfs_pkg::WaitDepthDef,
  parameter int unsigned RUN_DEPTH  = gjfs_pkg::RunDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gjfs_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gjfs_pkg::out_word_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [3:0]          cfg_data_i
);

  localparam int unsigned GPUS    = gjfs_pkg::GpusDef;
  localparam int unsigned ID_BITS = gjfs_pkg::IdBitsDef;
  localparam int unsigned WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned RW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int unsigned CW = $clog2(GPUS + 1);
  localparam int unsigned KW = (CW > 4) ? CW : 4;

  logic [3:0] gpu_total_q;
  logic       running_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpu_total_q <= gjfs_pkg::GpuTotalRst;
      running_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (gjfs_pkg::cfg_idx_e'(cfg_index_i))
        gjfs_pkg::CFG_GPU_TOTAL:       gpu_total_q <= cfg_data_i;
        gjfs_pkg::CFG_MACHINE_RUNNING: running_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // wait cell row
  logic              wv [WAIT_DEPTH+1];
  logic [ID_BITS-1:0] wid [WAIT_DEPTH+1];
  logic [3:0]        wcnt [WAIT_DEPTH+1];
  logic [GPUS-1:0]   wmsk [WAIT_DEPTH+1];
  logic [WAIT_DEPTH-1:0] first_free;
  gjfs_pkg::wait_ctl_t wctl;
  logic [WW-1:0]     cut_c;
  logic [ID_BITS-1:0] next_id_q;
  gjfs_pkg::in_word_t in_q;

  assign wv[WAIT_DEPTH]   = 1'b0;
  assign wid[WAIT_DEPTH]  = '0;
  assign wcnt[WAIT_DEPTH] = '0;
  assign wmsk[WAIT_DEPTH] = '0;

  for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_wait
    if (i == 0) begin : g_ff0
      assign first_free[i] = !wv[0];
    end else begin : g_ffn
      assign first_free[i] = !wv[i] && wv[i-1];
    end
    gjfs_wait_cell #(.IdBits(ID_BITS), .Gpus(GPUS)) u_cell (
      .clk_i, .rst_ni,
      .ctl_i(wctl),
      .cut_i(WW'(i) >= cut_c),
      .first_free_i(first_free[i]),
      .up_valid_i(wv[i+1]), .up_id_i(wid[i+1]),
      .up_count_i(wcnt[i+1]), .up_mask_i(wmsk[i+1]),
      .new_id_i(next_id_q), .new_count_i(in_q.req_count),
      .new_mask_i(in_q.req_mask),
      .valid_o(wv[i]), .id_o(wid[i]), .count_o(wcnt[i]), .mask_o(wmsk[i])
    );
  end

  // run slots
  logic [RUN_DEPTH-1:0] rv_q;
  logic [ID_BITS-1:0]   rid_q [RUN_DEPTH];
  logic [GPUS-1:0]      rmsk_q [RUN_DEPTH];
  logic [GPUS-1:0]      busy_q;

  gjfs_pkg::state_e state_q, state_d;
  logic out_v_q, out_v_d, pend_v_q, pend_v_d;
  gjfs_pkg::out_word_t out_q, out_d, pend_q, pend_d;
  logic id_inc, start_go, stop_go, out_free;

  // free mask of present gpus
  logic [GPUS-1:0] freem_c;
  logic [CW-1:0]   freecnt_c;
  always_comb begin
    freecnt_c = '0;
    for (int g = 0; g < GPUS; g++) begin
      freem_c[g] = (g < int'(gpu_total_q)) && !busy_q[g];
      freecnt_c  = freecnt_c + CW'(freem_c[g]);
    end
  end

  // lowest free run slot
  logic          slot_ok_c;
  logic [RW-1:0] slot_c;
  always_comb begin
    slot_ok_c = 1'b0;
    slot_c    = '0;
    for (int r = 0; r < RUN_DEPTH; r++) begin
      if (!rv_q[r] && !slot_ok_c) begin
        slot_ok_c = 1'b1;
        slot_c    = RW'(r);
      end
    end
  end

  // oldest waiting job that fits
  logic               pick_ok_c;
  logic [WW-1:0]      pick_c;
  logic [ID_BITS-1:0] pick_id_c;
  logic [3:0]         pick_cnt_c;
  logic [GPUS-1:0]    pick_msk_c;
  always_comb begin
    pick_ok_c  = 1'b0;
    pick_c     = '0;
    pick_id_c  = '0;
    pick_cnt_c = '0;
    pick_msk_c = '0;
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      if (!pick_ok_c && wv[i] && (KW'(wcnt[i]) <= KW'(freecnt_c)) &&
          ((wmsk[i] & ~freem_c) == '0)) begin
        pick_ok_c  = 1'b1;
        pick_c     = WW'(i);
        pick_id_c  = wid[i];
        pick_cnt_c = wcnt[i];
        pick_msk_c = wmsk[i];
      end
    end
  end

  // named job gets its set, otherwise the lowest free gpus
  logic [GPUS-1:0] grant_c;
  always_comb begin
    logic [CW-1:0] rank;
    rank    = '0;
    grant_c = pick_msk_c;
    if (pick_msk_c == '0) begin
      for (int g = 0; g < GPUS; g++) begin
        grant_c[g] = freem_c[g] && (KW'(rank) < KW'(pick_cnt_c));
        rank       = rank + CW'(freem_c[g]);
      end
    end
  end

  logic start_ok_c;
  assign start_ok_c = running_q && (freem_c != '0) && slot_ok_c && pick_ok_c;

  // cancel lookup: lowest running slot first, then the oldest waiting job
  logic          rmatch_c, wmatch_c;
  logic [RW-1:0] rhit_c;
  logic [WW-1:0] whit_c;
  always_comb begin
    rmatch_c = 1'b0;
    rhit_c   = '0;
    wmatch_c = 1'b0;
    whit_c   = '0;
    for (int r = 0; r < RUN_DEPTH; r++) begin
      if (!rmatch_c && rv_q[r] && rid_q[r] == in_q.task_id) begin
        rmatch_c = 1'b1;
        rhit_c   = RW'(r);
      end
    end
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      if (!wmatch_c && wv[i] && wid[i] == in_q.task_id) begin
        wmatch_c = 1'b1;
        whit_c   = WW'(i);
      end
    end
  end

  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    wctl     = '0;
    cut_c    = '0;
    id_inc   = 1'b0;
    start_go = 1'b0;
    stop_go  = 1'b0;
    unique case (state_q)
      gjfs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (gjfs_pkg::action_e'(in_data_i.action))
            gjfs_pkg::ACT_SUBMIT: state_d = gjfs_pkg::ST_SUBMIT;
            gjfs_pkg::ACT_CANCEL: state_d = gjfs_pkg::ST_CANCEL;
            gjfs_pkg::ACT_RETRY:  state_d = gjfs_pkg::ST_START;
            default: ;
          endcase
        end
      end
      gjfs_pkg::ST_SUBMIT: begin
        if (wv[WAIT_DEPTH-1]) begin
          pend_d = '{event_res: gjfs_pkg::EV_FULL, job_id: next_id_q,
                     gpu_mask: '0, last: 1'b0};
        end else begin
          wctl.load = 1'b1;
          id_inc    = 1'b1;
          pend_d = '{event_res: gjfs_pkg::EV_ACCEPTED, job_id: next_id_q,
                     gpu_mask: '0, last: 1'b0};
        end
        pend_v_d = 1'b1;
        state_d  = gjfs_pkg::ST_START;
      end
      gjfs_pkg::ST_CANCEL: begin
        if (out_free) begin
          out_v_d = 1'b1;
          state_d = gjfs_pkg::ST_IDLE;
          if (rmatch_c) begin
            stop_go = 1'b1;
            out_d = '{event_res: gjfs_pkg::EV_STOPPED, job_id: in_q.task_id,
                      gpu_mask: rmsk_q[rhit_c], last: 1'b1};
          end else if (wmatch_c) begin
            wctl.shift = 1'b1;
            cut_c      = whit_c;
            out_d = '{event_res: gjfs_pkg::EV_CANCELLED, job_id: in_q.task_id,
                      gpu_mask: '0, last: 1'b1};
          end else begin
            out_d = '{event_res: gjfs_pkg::EV_UNKNOWN, job_id: in_q.task_id,
                      gpu_mask: '0, last: 1'b1};
          end
        end
      end
      gjfs_pkg::ST_START: begin
        // a held word means a submit, which keeps trying until a try fails
        if (out_free) begin
          if (start_ok_c) begin
            start_go   = 1'b1;
            wctl.shift = 1'b1;
            cut_c      = pick_c;
            out_v_d    = 1'b1;
            if (pend_v_q) begin
              out_d  = pend_q;
              pend_d = '{event_res: gjfs_pkg::EV_STARTED, job_id: pick_id_c,
                         gpu_mask: grant_c, last: 1'b0};
            end else begin
              out_d = '{event_res: gjfs_pkg::EV_STARTED, job_id: pick_id_c,
                        gpu_mask: grant_c, last: 1'b1};
              state_d = gjfs_pkg::ST_IDLE;
            end
          end else begin
            if (pend_v_q) begin
              out_d      = pend_q;
              out_d.last = 1'b1;
              out_v_d    = 1'b1;
              pend_v_d   = 1'b0;
            end
            state_d = gjfs_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = gjfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gjfs_pkg::ST_IDLE;
      out_v_q   <= 1'b0;
      out_q     <= '0;
      pend_v_q  <= 1'b0;
      pend_q    <= '0;
      busy_q    <= '0;
      rv_q      <= '0;
      next_id_q <= '0;
    end else begin
      state_q  <= state_d;
      out_v_q  <= out_v_d;
      out_q    <= out_d;
      pend_v_q <= pend_v_d;
      pend_q   <= pend_d;
      if (id_inc) begin
        next_id_q <= next_id_q + 1'b1;
      end
      if (start_go) begin
        busy_q       <= busy_q | grant_c;
        rv_q[slot_c] <= 1'b1;
      end else if (stop_go) begin
        busy_q       <= busy_q & ~rmsk_q[rhit_c];
        rv_q[rhit_c] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (start_go) begin
      rid_q[slot_c]  <= pick_id_c;
      rmsk_q[slot_c] <= grant_c;
    end
  end

  assign in_ready_o  = (state_q == gjfs_pkg::ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== bench/gpu_job_first_fit_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpu_job_first_fit_scheduler_tb
// self-checking bench: directed rows then random submit/cancel/retry traffic
// ----------------------------------------------------------------------------
// A predictor tracks the wait queue, run slots, busy map and next id and
// queues the expected event words for each accepted input word. Result words
// are compared field by field in order. Settings of gpu_total and
// machine_running change between phases while the block is idle.
module gpu_job_first_fit_scheduler_tb;

  localparam int NGPU    = 8;
  localparam int NWAIT   = 16;
  localparam int NRUN    = 16;
  localparam int WDOG    = 20000;
  localparam int NPHASES = 6;

  typedef struct {
    gjfs_pkg::in_word_t  word;
    bit                  has_exp;
    gjfs_pkg::out_word_t exp_word;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  gjfs_pkg::in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  gjfs_pkg::out_word_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_index_i = 1'b0;
  logic [3:0] cfg_data_i = '0;

  gpu_job_first_fit_scheduler u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]  gpu_total_q;
  logic        running_q;
  bit          wq_valid [NWAIT];
  logic [15:0] wq_id [NWAIT];
  logic [3:0]  wq_count [NWAIT];
  logic [7:0]  wq_mask [NWAIT];
  bit          rs_valid [NRUN];
  logic [15:0] rs_id [NRUN];
  logic [7:0]  rs_mask [NRUN];
  logic [7:0]  busy_q;
  logic [15:0] next_id_q;

  gjfs_pkg::out_word_t pending_events[$];
  gjfs_pkg::out_word_t directed_exp[$];
  bit          directed_chk[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          timed_out = 0;
  bit          accepting = 1'b1;
  int          wait_len;

  function automatic void push_event(gjfs_pkg::event_e ev, logic [15:0] id, logic [7:0] m);
    gjfs_pkg::out_word_t w;
    w.event_res = ev;
    w.job_id = id;
    w.gpu_mask = m;
    w.last = 1'b0;
    pending_events.push_back(w);
  endfunction

  function automatic void drop_waiting(int k);
    for (int i = k; i < NWAIT - 1; i++) begin
      wq_valid[i] = wq_valid[i+1];
      wq_id[i] = wq_id[i+1];
      wq_count[i] = wq_count[i+1];
      wq_mask[i] = wq_mask[i+1];
    end
    wq_valid[NWAIT-1] = 0;
  endfunction

  function automatic bit try_start();
    int n, slot, pick, cnt, got;
    logic [7:0] freem, grant;
    slot = -1;
    pick = -1;
    if (!running_q) return 0;
    n = (gpu_total_q > NGPU) ? NGPU : gpu_total_q;
    freem = 8'((9'd1 << n) - 1) & ~busy_q;
    if (freem == 0) return 0;
    for (int i = 0; i < NRUN; i++) if (!rs_valid[i] && slot < 0) slot = i;
    if (slot < 0) return 0;
    cnt = $countones(freem);
    for (int i = 0; i < NWAIT; i++)
      if (pick < 0 && wq_valid[i] && wq_count[i] <= cnt && (wq_mask[i] & ~freem) == 0)
        pick = i;
    if (pick < 0) return 0;
    if (wq_mask[pick] == 0) begin
      grant = 0;
      got = 0;
      for (int g = 0; g < NGPU; g++)
        if (freem[g] && got < wq_count[pick]) begin
          grant[g] = 1'b1;
          got++;
        end
    end else begin
      grant = wq_mask[pick];
    end
    busy_q |= grant;
    rs_valid[slot] = 1;
    rs_id[slot] = wq_id[pick];
    rs_mask[slot] = grant;
    push_event(gjfs_pkg::EV_STARTED, wq_id[pick], grant);
    drop_waiting(pick);
    return 1;
  endfunction

  // returns number of event words queued for this input word
  function automatic int predict_events(gjfs_pkg::in_word_t w);
    int k, slot;
    bit found;
    k = pending_events.size();
    found = 0;
    slot = -1;
    case (gjfs_pkg::action_e'(w.action))
      gjfs_pkg::ACT_SUBMIT: begin
        for (int i = 0; i < NWAIT; i++) if (!wq_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          push_event(gjfs_pkg::EV_FULL, next_id_q, 0);
        end else begin
          wq_valid[slot] = 1;
          wq_id[slot] = next_id_q;
          wq_count[slot] = w.req_count;
          wq_mask[slot] = w.req_mask;
          push_event(gjfs_pkg::EV_ACCEPTED, next_id_q, 0);
          next_id_q++;
        end
        for (int j = 0; j < NWAIT; j++) if (!try_start()) break;
      end
      gjfs_pkg::ACT_CANCEL: begin
        for (int i = 0; i < NRUN; i++)
          if (!found && rs_valid[i] && rs_id[i] == w.task_id) begin
            busy_q &= ~rs_mask[i];
            rs_valid[i] = 0;
            push_event(gjfs_pkg::EV_STOPPED, rs_id[i], rs_mask[i]);
            found = 1;
          end
        for (int i = 0; i < NWAIT; i++)
          if (!found && wq_valid[i] && wq_id[i] == w.task_id) begin
            push_event(gjfs_pkg::EV_CANCELLED, wq_id[i], 0);
            drop_waiting(i);
            found = 1;
          end
        if (!found) push_event(gjfs_pkg::EV_UNKNOWN, w.task_id, 0);
      end
      gjfs_pkg::ACT_RETRY: void'(try_start());
      default: ;
    endcase
    if (pending_events.size() > k)
      pending_events[pending_events.size()-1].last = 1'b1;
    return pending_events.size() - k;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // pick an id that is likely live
  function automatic logic [15:0] live_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) for (int i = 0; i < NRUN; i++) if (rs_valid[i] && $urandom_range(0, 2) == 0)
      return rs_id[i];
    if (r < 8) for (int i = 0; i < NWAIT; i++) if (wq_valid[i] && $urandom_range(0, 1) == 0)
      return wq_id[i];
    return (r == 9) ? 16'($urandom) : next_id_q - 16'($urandom_range(1, 20));
  endfunction

  // valid drops at acceptance; the next word follows after a random gap
  task automatic send_word(gjfs_pkg::in_word_t w, bit has_exp, gjfs_pkg::out_word_t ew);
    int n;
    repeat (1 + short_gap()) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
    n = predict_events(w);
    for (int i = 0; i < n; i++) begin
      directed_chk.push_back(has_exp && i == 0);
      directed_exp.push_back(ew);
    end
  endtask

  task automatic write_reg(gjfs_pkg::cfg_idx_e idx, logic [3:0] val);
    repeat (60) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == gjfs_pkg::CFG_GPU_TOTAL) gpu_total_q = val;
    else running_q = val[0];
  endtask

  task automatic drain();
    while (pending_events.size() != 0) @(posedge clk_i);
  endtask

  function automatic gjfs_pkg::in_word_t mk(gjfs_pkg::action_e a, int id, int cnt, int m);
    gjfs_pkg::in_word_t w;
    w.action = a;
    w.task_id = 16'(id);
    w.req_count = 4'(cnt);
    w.req_mask = 8'(m);
    return w;
  endfunction

  function automatic gjfs_pkg::out_word_t ev_word(gjfs_pkg::event_e e, int id, int m, bit l);
    gjfs_pkg::out_word_t w;
    w.event_res = e;
    w.job_id = 16'(id);
    w.gpu_mask = 8'(m);
    w.last = l;
    return w;
  endfunction

  // output side: random stalls, compare against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", out_data_o);
        end else begin
          gjfs_pkg::out_word_t e;
          bit dchk;
          gjfs_pkg::out_word_t dexp;
          e = pending_events.pop_front();
          dchk = directed_chk.pop_front();
          dexp = directed_exp.pop_front();
          if (dchk && dexp != e) begin
            mismatches++;
            if (mismatches <= 10) $display("table row disagrees: %p vs %p", dexp, e);
          end
          if (out_data_o.event_res !== e.event_res || out_data_o.job_id !== e.job_id ||
              out_data_o.gpu_mask !== e.gpu_mask || out_data_o.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_data_o);
          end
        end
      end
      if (wait_len > 0) begin
        wait_len--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        wait_len = short_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !accepting)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG && !timed_out) begin
      timed_out = 1;
      $display("[gpu_job_first_fit_scheduler] ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    gjfs_pkg::out_word_t none;
    int na;
    logic [3:0] totals [NPHASES];
    none = '0;
    wait_len = 0;
    gpu_total_q = 4'd8;
    running_q = 1'b1;
    busy_q = '0;
    next_id_q = '0;
    for (int i = 0; i < NWAIT; i++) wq_valid[i] = 0;
    for (int i = 0; i < NRUN; i++) rs_valid[i] = 0;
    totals = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd8};

    // directed table
    rows.push_back('{mk(gjfs_pkg::ACT_CANCEL, 16'hffff, 0, 0), 1,
                     ev_word(gjfs_pkg::EV_UNKNOWN, 16'hffff, 0, 1)});
    rows.push_back('{mk(gjfs_pkg::ACT_RETRY, 0, 0, 0), 0, none});
    rows.push_back('{mk(gjfs_pkg::ACT_NONE, 16'hffff, 15, 255), 0, none});
    rows.push_back('{mk(gjfs_pkg::ACT_SUBMIT, 0, 8, 0), 1,
                     ev_word(gjfs_pkg::EV_ACCEPTED, 0, 0, 0)});
    rows.push_back('{mk(gjfs_pkg::ACT_SUBMIT, 0, 0, 8'h01), 1,
                     ev_word(gjfs_pkg::EV_ACCEPTED, 1, 0, 1)});
    rows.push_back('{mk(gjfs_pkg::ACT_CANCEL, 0, 0, 0), 1,
                     ev_word(gjfs_pkg::EV_STOPPED, 0, 8'hff, 1)});
    rows.push_back('{mk(gjfs_pkg::ACT_SUBMIT, 0, 0, 8'hff), 0, none});
    rows.push_back('{mk(gjfs_pkg::ACT_SUBMIT, 0, 15, 0), 0, none});
    rows.push_back('{mk(gjfs_pkg::ACT_CANCEL, 2, 0, 0), 0, none});
    rows.push_back('{mk(gjfs_pkg::ACT_SUBMIT, 16'hffff, 3, 8'h80), 0, none});
    rows.push_back('{mk(gjfs_pkg::ACT_SUBMIT, 0, 2, 0), 0, none});
    rows.push_back('{mk(gjfs_pkg::ACT_CANCEL, 3, 0, 0), 0, none});
    rows.push_back('{mk(gjfs_pkg::ACT_RETRY, 0, 0, 0), 0, none});
    rows.push_back('{mk(gjfs_pkg::ACT_CANCEL, 4, 0, 0), 0, none});
    for (int i = 0; i < 18; i++)
      rows.push_back('{mk(gjfs_pkg::ACT_SUBMIT, 0, 8, 0), 0, none});
    rows.push_back('{mk(gjfs_pkg::ACT_CANCEL, 4, 0, 0), 0, none});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    foreach (rows[i]) send_word(rows[i].word, rows[i].has_exp, rows[i].exp_word);
    drain();
    // clear everything out
    for (int i = 0; i < 40; i++) send_word(mk(gjfs_pkg::ACT_CANCEL, i, 0, 0), 0, none);
    drain();

    for (int p = 0; p < NPHASES; p++) begin
      write_reg(gjfs_pkg::CFG_GPU_TOTAL, totals[p]);
      write_reg(gjfs_pkg::CFG_MACHINE_RUNNING, (p == 2) ? 4'd0 : 4'd1);
      for (int i = 0; i < 70; i++) begin
        gjfs_pkg::in_word_t w;
        int r;
        r = $urandom_range(0, 99);
        w = mk(gjfs_pkg::ACT_NONE, $urandom, $urandom, $urandom);
        if (r < 45) begin
          w.action = gjfs_pkg::ACT_SUBMIT;
          w.req_count = 4'($urandom_range(0, 4));
          na = $urandom_range(0, 9);
          w.req_mask = (na < 6) ? 8'h00 : (na < 9) ? 8'(1 << $urandom_range(0, 7)) :
                       8'($urandom);
          if ($urandom_range(0, 19) == 0) w.req_count = 4'($urandom);
        end else if (r < 85) begin
          w.action = gjfs_pkg::ACT_CANCEL;
          w.task_id = live_id();
        end else if (r < 97) begin
          w.action = gjfs_pkg::ACT_RETRY;
        end else begin
          w.action = gjfs_pkg::ACT_NONE;
        end
        send_word(w, 0, none);
        if (i == 35) drain();
      end
      drain();
      if (p == 2) begin
        write_reg(gjfs_pkg::CFG_MACHINE_RUNNING, 4'd1);
        for (int i = 0; i < 4; i++) send_word(mk(gjfs_pkg::ACT_RETRY, 0, 0, 0), 0, none);
        drain();
      end
    end

    drain();
    accepting = 1'b0;
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_events.size() == 0)
      $display("[gpu_job_first_fit_scheduler] OK");
    else
      $display("[gpu_job_first_fit_scheduler] ERROR");
    $finish;
  end

endmodule
